/* src/u8d_pkg.sv */
package u8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;

	// lead byte class bits and payload masks
	localparam logic [BYTE_W-1:0] LEAD1_BIT  = 8'b1000_0000;
	localparam logic [BYTE_W-1:0] LEAD2_BIT  = 8'b0010_0000;
	localparam logic [BYTE_W-1:0] LEAD3_BIT  = 8'b0001_0000;
	localparam logic [BYTE_W-1:0] LEAD4_BIT  = 8'b0000_1000;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'b0001_1111;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b0000_1111;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b0000_0111;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b0011_1111;

	localparam int CONT_W = 6;

	// continuation bytes still expected
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_ONE   = 2'd1;
	localparam logic [1:0] PEND_TWO   = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic            load;
		logic [CP_W-1:0] code_point;
	} emit_t;

endpackage

/* src/u8d_stream_if.sv */
interface u8d_byte_if;
	import u8d_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;
	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface u8d_cp_if;
	import u8d_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	modport source (output valid, output code_point, input ready);
	modport sink (input valid, input code_point, output ready);
endinterface

/* src/u8d_in_stage.sv */
module u8d_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	u8d_byte_if.sink                   byte_stream,
	input  logic                       take,
	output logic                       vld_s1,
	output logic [u8d_pkg::BYTE_W-1:0] byte_s1
);
	import u8d_pkg::*;

	assign byte_stream.ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			vld_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.byte_in;
		end
	end

endmodule

/* src/u8d_decode.sv */
module u8d_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld_s1,
	input  logic [u8d_pkg::BYTE_W-1:0] byte_s1,
	input  logic                       out_free,
	output logic                       take,
	output u8d_pkg::emit_t             emit
);
	import u8d_pkg::*;

	logic [1:0]      pending_q;
	logic [CP_W-1:0] partial_q;
	logic [1:0]      pending_nx;
	logic [CP_W-1:0] partial_nx;
	logic            want_emit;
	logic [CP_W-1:0] emit_val;
	logic [CP_W-1:0] shifted;

	assign shifted = {partial_q[CP_W-CONT_W-1:0], byte_s1[CONT_W-1:0] & CONT_MASK[CONT_W-1:0]};

	always_comb begin
		pending_nx = pending_q;
		partial_nx = partial_q;
		want_emit  = 1'b0;
		emit_val   = shifted;
		if (pending_q == PEND_NONE) begin
			if ((byte_s1 & LEAD1_BIT) == '0) begin
				want_emit = 1'b1;
				emit_val  = {{(CP_W-BYTE_W){1'b0}}, byte_s1};
			end else if ((byte_s1 & LEAD2_BIT) == '0) begin
				partial_nx = {{(CP_W-BYTE_W){1'b0}}, byte_s1 & LEAD2_MASK};
				pending_nx = PEND_ONE;
			end else if ((byte_s1 & LEAD3_BIT) == '0) begin
				partial_nx = {{(CP_W-BYTE_W){1'b0}}, byte_s1 & LEAD3_MASK};
				pending_nx = PEND_TWO;
			end else if ((byte_s1 & LEAD4_BIT) == '0) begin
				partial_nx = {{(CP_W-BYTE_W){1'b0}}, byte_s1 & LEAD4_MASK};
				pending_nx = PEND_THREE;
			end
			// 11111xxx: dropped, state untouched
		end else begin
			pending_nx = pending_q - 2'd1;
			if (pending_q == PEND_ONE) begin
				want_emit  = 1'b1;
				partial_nx = '0;
			end else begin
				partial_nx = shifted;
			end
		end
	end

	// a byte that yields nothing never waits on the output side
	assign take            = vld_s1 && (!want_emit || out_free);
	assign emit.load       = take && want_emit;
	assign emit.code_point = emit_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PEND_NONE;
			partial_q <= '0;
		end else if (take) begin
			pending_q <= pending_nx;
			partial_q <= partial_nx;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> out_free)
		else $error("code point loaded into a full output register");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == PEND_NONE |-> partial_q == '0)
		else $error("accumulator not clear between sequences");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == PEND_ONE   |-> partial_q[CP_W-1:15] == '0) and
		(pending_q == PEND_TWO   |-> partial_q[CP_W-1:9] == '0) and
		(pending_q == PEND_THREE |-> partial_q[CP_W-1:3] == '0))
		else $error("accumulator wider than the bytes seen so far");

	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		take && pending_q == PEND_ONE |-> emit.load ##1 pending_q == PEND_NONE)
		else $error("last continuation byte did not complete the sequence");

endmodule

/* src/u8d_out_reg.sv */
module u8d_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  u8d_pkg::emit_t emit,
	output logic           out_free,
	u8d_cp_if.source       cp_stream
);
	import u8d_pkg::*;

	logic            vld_s2;
	logic [CP_W-1:0] code_point_s2;

	assign out_free             = !vld_s2 || cp_stream.ready;
	assign cp_stream.valid      = vld_s2;
	assign cp_stream.code_point = code_point_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (emit.load) begin
			vld_s2 <= 1'b1;
		end else if (cp_stream.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			code_point_s2 <= emit.code_point;
		end
	end

endmodule

/* src/utf8_byte_stream_decoder.sv */
// A byte is registered in the input stage (vld_s1, byte_s1) and decoded there;
// its code point is then registered in the output register (vld_s2), which
// drives cp_stream.
// Throughput: one byte per cycle while cp_stream is not stalled.
// Stalls on cp_stream hold only bytes that complete a code point.
// Reset (arst_n low): pipeline empty, no continuation bytes pending, accumulator zero.
module utf8_byte_stream_decoder (
	input  logic     clk,
	input  logic     arst_n,
	u8d_byte_if.sink byte_stream,
	u8d_cp_if.source cp_stream
);
	import u8d_pkg::*;

	logic              take;
	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	emit_t             emit;

	u8d_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.take        (take),
		.vld_s1      (vld_s1),
		.byte_s1     (byte_s1)
	);

	u8d_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.take     (take),
		.emit     (emit)
	);

	u8d_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.out_free  (out_free),
		.cp_stream (cp_stream)
	);

endmodule
